/* sv/linked_list_queue_engine_core_assert.svh */
// Assertion macros used by the queue engine datapath.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LINKED_LIST_QUEUE_ENGINE_CORE_ASSERT_SVH
`define LINKED_LIST_QUEUE_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLQE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LLQE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/llqe_pkg.sv */
package llqe_pkg;

  localparam int ELEM_W     = 4;
  localparam int ELEM_RANGE = 1 << ELEM_W;
  localparam int LEN_W      = 5;

  typedef enum logic {
    MODE_APPEND = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_DUP     = 2'd1,
    STAT_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LINK,
    S_COMMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic phase1;
    logic commit;
  } llqe_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } llqe_stat_t;

endpackage

/* sv/llqe_cmd_if.sv */
interface llqe_cmd_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [3:0] element_index;

  modport source (output valid, output mode, output element_index, input ready);
  modport sink (input valid, input mode, input element_index, output ready);
endinterface

/* sv/llqe_rsp_if.sv */
interface llqe_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] queue_length;
  logic [3:0] head_slot;
  logic       head_valid;

  modport source (
    output valid, output status, output queue_length, output head_slot,
    output head_valid, input ready
  );
  modport sink (
    input valid, input status, input queue_length, input head_slot,
    input head_valid, output ready
  );
endinterface

/* sv/linked_list_queue_engine_core.sv */
// Queue engine over a pool of element slots kept as a circular doubly linked
// list. Each command item appends an element at the tail or removes a named
// element from anywhere in the queue, and yields one result item with the
// status, the new queue length and the head slot. A command has a link step
// and a commit step: the first writes the tail splice of an append or reads
// both links of the slot being removed, the second writes the remaining
// links and commits. Each link memory has a single write port. Commands
// issue back to back while results are taken; a result not yet taken holds
// the engine in its commit step. Slots past index 15 are unreachable, so at
// most 16 slots are built. Link memories need no clearing after reset; the
// block accepts commands in the cycle after reset drops.
module linked_list_queue_engine_core #(
  parameter int NUM_SLOTS = 16
) (
  input logic        clk,
  input logic        rst,
  llqe_cmd_if.sink   in_ch,
  llqe_rsp_if.source out_ch
);

  import llqe_pkg::*;

  llqe_ctrl_t ctrl;
  llqe_stat_t stat;

  llqe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  llqe_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_mode          (in_ch.mode),
    .in_element_index (in_ch.element_index),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_queue_length (out_ch.queue_length),
    .out_head_slot    (out_ch.head_slot),
    .out_head_valid   (out_ch.head_valid)
  );

endmodule

/* sv/llqe_ram.sv */
module llqe_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/llqe_ctrl.sv */
module llqe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output llqe_pkg::llqe_ctrl_t ctrl,
  input  llqe_pkg::llqe_stat_t stat
);

  import llqe_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        ctrl.phase1 = 1'b1;
        state_next  = S_COMMIT;
      end
      S_COMMIT: begin
        // Hold here until the result register can take the item.
        if (!stat.out_busy) begin
          ctrl.commit = 1'b1;
          in_ready    = 1'b1;
          if (in_valid) begin
            ctrl.load  = 1'b1;
            state_next = S_LINK;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // No item is taken while reset is held.
    if (rst) begin
      in_ready = 1'b0;
      ctrl     = '0;
    end
  end

endmodule

/* sv/llqe_datapath.sv */
`include "linked_list_queue_engine_core_assert.svh"

module llqe_datapath #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  llqe_pkg::llqe_ctrl_t ctrl,
  output llqe_pkg::llqe_stat_t stat,
  input  logic                 in_mode,
  input  logic [3:0]           in_element_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [4:0]           out_queue_length,
  output logic [3:0]           out_head_slot,
  output logic                 out_head_valid
);

  import llqe_pkg::*;

  // Slots past the reach of the element index can never be queued.
  localparam int POOL = (NUM_SLOTS < ELEM_RANGE) ? NUM_SLOTS : ELEM_RANGE;
  localparam int IW   = $clog2(POOL);
  localparam int CW   = $clog2(POOL + 1);

  mode_t             mode;
  logic [ELEM_W-1:0] elem;
  logic [POOL-1:0]   flags, flags_next;
  logic [IW-1:0]     head, head_next;
  logic [IW-1:0]     tail, tail_next;
  logic [CW-1:0]     count, count_next;

  logic [31:0]   elem_ext;
  logic [IW-1:0] slot;
  logic          in_range;
  logic          member;
  logic          count_zero;
  logic          count_one;
  status_t       status;
  logic          do_append;
  logic          do_remove;

  logic          nx_we, pv_we, rd_en;
  logic [IW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;
  logic [IW-1:0] next_rd, prev_rd;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mode <= mode_t'(in_mode);
      elem <= in_element_index;
    end
  end

  assign elem_ext   = 32'(elem);
  assign slot       = elem_ext[IW-1:0];
  assign in_range   = elem_ext < 32'(POOL);
  assign member     = in_range && flags[slot];
  assign count_zero = (count == '0);
  assign count_one  = (count == CW'(1));

  always_comb begin
    if (!in_range) begin
      status = STAT_MISSING;
    end else if (mode == MODE_APPEND) begin
      status = member ? STAT_DUP : STAT_OK;
    end else begin
      status = member ? STAT_OK : STAT_MISSING;
    end
  end

  assign do_append = (status == STAT_OK) && (mode == MODE_APPEND);
  assign do_remove = (status == STAT_OK) && (mode == MODE_REMOVE);

  // Link writes: the first step splices the new slot behind the tail,
  // the commit step closes the ring back to the head. A removal reads
  // both links of the slot first and bridges its neighbors at commit.
  always_comb begin
    nx_we = 1'b0;
    pv_we = 1'b0;
    rd_en = 1'b0;
    nx_wa = slot;
    nx_wd = slot;
    pv_wa = slot;
    pv_wd = slot;
    if (ctrl.phase1) begin
      if (do_append) begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        if (!count_zero) begin
          nx_wa = tail;
          pv_wd = tail;
        end
      end
      if (do_remove) begin
        rd_en = 1'b1;
      end
    end
    if (ctrl.commit) begin
      if (do_append && !count_zero) begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        nx_wd = head;
        pv_wa = head;
      end
      if (do_remove && !count_one) begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        nx_wa = prev_rd;
        nx_wd = next_rd;
        pv_wa = next_rd;
        pv_wd = prev_rd;
      end
    end
  end

  llqe_ram #(.WIDTH(IW), .DEPTH(POOL)) u_next_ram (
    .clk     (clk),
    .wr_en   (nx_we),
    .wr_addr (nx_wa),
    .wr_data (nx_wd),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (next_rd)
  );

  llqe_ram #(.WIDTH(IW), .DEPTH(POOL)) u_prev_ram (
    .clk     (clk),
    .wr_en   (pv_we),
    .wr_addr (pv_wa),
    .wr_data (pv_wd),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (prev_rd)
  );

  always_comb begin
    flags_next = flags;
    count_next = count;
    head_next  = head;
    tail_next  = tail;
    if (do_append) begin
      flags_next[slot] = 1'b1;
      count_next       = count + CW'(1);
      tail_next        = slot;
      if (count_zero) begin
        head_next = slot;
      end
    end
    if (do_remove) begin
      flags_next[slot] = 1'b0;
      count_next       = count - CW'(1);
      // Removing the only element leaves head and tail as they were.
      if (!count_one) begin
        if (slot == head) begin
          head_next = next_rd;
        end
        if (slot == tail) begin
          tail_next = prev_rd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      count <= '0;
      head  <= '0;
      tail  <= '0;
    end else if (ctrl.commit) begin
      flags <= flags_next;
      count <= count_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_status       <= status;
      out_queue_length <= LEN_W'(count_next);
      out_head_slot    <= (count_next != '0) ? ELEM_W'(head_next) : '0;
      out_head_valid   <= (count_next != '0);
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

  `LLQE_ASSERT_SAME(a_count_matches_flags, 1'b1, ($countones(flags) == int'(count)),
                    "queue count differs from number of member flags")
  `LLQE_ASSERT_SAME(a_head_is_member, (count != '0), flags[head],
                    "head slot of a nonempty queue is not a member")
  `LLQE_ASSERT_SAME(a_tail_is_member, (count != '0), flags[tail],
                    "tail slot of a nonempty queue is not a member")
  `LLQE_ASSERT_SAME(a_commit_not_stalled, ctrl.commit, !(out_valid && !out_ready),
                    "result committed over an item still waiting")

endmodule

/* sim/tb.sv */
module tb;
  import llqe_pkg::*;

  // One result item as the engine reports it.
  typedef struct packed {
    status_t    status;
    logic [4:0] len;
    logic [3:0] head;
    logic       hvalid;
  } qresult_t;

  // One row of the directed table. Where literal_want is set, the row's result is
  // typed in; otherwise it comes from the queue predictor.
  typedef struct packed {
    mode_t      mode;
    logic [3:0] elem;
    logic       literal_want;
    qresult_t   want;
  } cmd_row_t;

  localparam int       DIR_ROWS     = 25;
  localparam int       RAND_ITEMS   = 1425;
  localparam int       HOLD_CYCLES  = 400;
  localparam int       HOLD_AT      = 250;
  localparam int       PAUSE_AT     = 700;
  localparam qresult_t PREDICTED    = '{STAT_OK, 5'd0, 4'd0, 1'b0};

  logic clk;
  logic rst = 1'b1;

  llqe_cmd_if cmd_ch ();
  llqe_rsp_if rsp_ch ();

  linked_list_queue_engine_core #(.NUM_SLOTS(16)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (cmd_ch),
    .out_ch (rsp_ch)
  );

  // Predictor copy of the linked list.
  logic [3:0] q_next [16];
  logic [3:0] q_prev [16];
  logic       q_member [16];
  logic [3:0] q_head;
  logic [4:0] q_count;

  qresult_t pending_results [$];
  int       errors = 0;
  int       results_taken = 0;

  cmd_row_t dir_table [DIR_ROWS] = '{
    '{MODE_REMOVE, 4'd0,  1'b1, '{STAT_MISSING, 5'd0,  4'd0,  1'b0}},
    '{MODE_APPEND, 4'd15, 1'b1, '{STAT_OK,      5'd1,  4'd15, 1'b1}},
    '{MODE_APPEND, 4'd15, 1'b1, '{STAT_DUP,     5'd1,  4'd15, 1'b1}},
    '{MODE_REMOVE, 4'd0,  1'b1, '{STAT_MISSING, 5'd1,  4'd15, 1'b1}},
    '{MODE_REMOVE, 4'd15, 1'b1, '{STAT_OK,      5'd0,  4'd0,  1'b0}},
    '{MODE_APPEND, 4'd0,  1'b1, '{STAT_OK,      5'd1,  4'd0,  1'b1}},
    '{MODE_APPEND, 4'd1,  1'b0, PREDICTED},
    '{MODE_APPEND, 4'd2,  1'b0, PREDICTED},
    '{MODE_APPEND, 4'd3,  1'b0, PREDICTED},
    '{MODE_APPEND, 4'd4,  1'b0, PREDICTED},
    '{MODE_APPEND, 4'd5,  1'b0, PREDICTED},
    '{MODE_APPEND, 4'd6,  1'b0, PREDICTED},
    '{MODE_APPEND, 4'd7,  1'b0, PREDICTED},
    '{MODE_APPEND, 4'd8,  1'b0, PREDICTED},
    '{MODE_APPEND, 4'd9,  1'b0, PREDICTED},
    '{MODE_APPEND, 4'd10, 1'b0, PREDICTED},
    '{MODE_APPEND, 4'd11, 1'b0, PREDICTED},
    '{MODE_APPEND, 4'd12, 1'b0, PREDICTED},
    '{MODE_APPEND, 4'd13, 1'b0, PREDICTED},
    '{MODE_APPEND, 4'd14, 1'b0, PREDICTED},
    '{MODE_APPEND, 4'd15, 1'b1, '{STAT_OK,      5'd16, 4'd0,  1'b1}},
    '{MODE_APPEND, 4'd7,  1'b1, '{STAT_DUP,     5'd16, 4'd0,  1'b1}},
    '{MODE_REMOVE, 4'd0,  1'b0, PREDICTED},
    '{MODE_REMOVE, 4'd15, 1'b0, PREDICTED},
    '{MODE_REMOVE, 4'd7,  1'b0, PREDICTED}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic qresult_t queue_apply(mode_t m, logic [3:0] e);
    qresult_t   r;
    logic [3:0] tail;
    logic [3:0] p;
    logic [3:0] n;
    r.status = STAT_OK;
    if (m == MODE_APPEND) begin
      if (q_member[e]) begin
        r.status = STAT_DUP;
      end else begin
        if (q_count == 0) begin
          q_head = e;
          q_next[e] = e;
          q_prev[e] = e;
        end else begin
          tail = q_prev[q_head];
          q_next[tail] = e;
          q_prev[e] = tail;
          q_next[e] = q_head;
          q_prev[q_head] = e;
        end
        q_member[e] = 1'b1;
        q_count = q_count + 5'd1;
      end
    end else if (q_count == 0 || !q_member[e]) begin
      r.status = STAT_MISSING;
    end else begin
      if (q_count == 1) begin
        q_count = 5'd0;
      end else begin
        p = q_prev[e];
        n = q_next[e];
        q_next[p] = n;
        q_prev[n] = p;
        if (e == q_head) q_head = n;
        q_count = q_count - 5'd1;
      end
      q_member[e] = 1'b0;
    end
    r.len    = q_count;
    r.head   = (q_count != 0) ? q_head : 4'd0;
    r.hvalid = (q_count != 0);
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task automatic offer_cmd(mode_t m, logic [3:0] e, logic literal_want, qresult_t want,
                           bit calm);
    int unsigned gap;
    qresult_t    predicted;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.mode          <= m;
    cmd_ch.element_index <= e;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    predicted = queue_apply(m, e);
    pending_results.push_back(literal_want ? want : predicted);
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off that lets the
  // engine back up into its command input.
  initial begin
    int unsigned gap;
    bit          held;
    qresult_t    want;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_taken == HOLD_AT) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else if ((results_taken / 150) % 4 == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 19);
      end
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result item %0d arrived with nothing pending", results_taken));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status != want.status)
          flag_mismatch($sformatf("item %0d status %0d, expected %0d",
                                  results_taken, rsp_ch.status, want.status));
        if (rsp_ch.queue_length != want.len)
          flag_mismatch($sformatf("item %0d queue_length %0d, expected %0d",
                                  results_taken, rsp_ch.queue_length, want.len));
        if (rsp_ch.head_slot != want.head)
          flag_mismatch($sformatf("item %0d head_slot %0d, expected %0d",
                                  results_taken, rsp_ch.head_slot, want.head));
        if (rsp_ch.head_valid != want.hvalid)
          flag_mismatch($sformatf("item %0d head_valid %0d, expected %0d",
                                  results_taken, rsp_ch.head_valid, want.hvalid));
      end
      results_taken++;
    end
  end

  initial begin
    bit         filling;
    bit         do_append;
    logic [3:0] elem;
    int         picks [$];
    mode_t      m;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.mode          <= MODE_APPEND;
    cmd_ch.element_index <= 4'd0;
    for (int i = 0; i < 16; i++) begin
      q_next[i]   = 4'd0;
      q_prev[i]   = 4'd0;
      q_member[i] = 1'b0;
    end
    q_head  = 4'd0;
    q_count = 5'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[r])
      offer_cmd(dir_table[r].mode, dir_table[r].elem, dir_table[r].literal_want,
                dir_table[r].want, 1'b0);

    // Mostly sensible traffic: fill and drain phases that pick queued or free slots,
    // with some blind indices mixed in to hit duplicates and misses.
    filling = 1'b1;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == PAUSE_AT) begin
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if (q_count == 16) filling = 1'b0;
      else if (q_count == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 3) filling = !filling;
      do_append = ($urandom_range(0, 99) < (filling ? 75 : 25));
      elem = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 8) begin
        picks.delete();
        for (int s = 0; s < 16; s++)
          if (q_member[s] != do_append) picks.push_back(s);
        if (picks.size() != 0) elem = 4'(picks[$urandom_range(0, picks.size() - 1)]);
      end
      m = do_append ? MODE_APPEND : MODE_REMOVE;
      offer_cmd(m, elem, 1'b0, PREDICTED, (i / 150) % 4 == 3);
    end

    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
